>>> hw/rtl/polygon_metrics_core_defines.svh
// ----------------------------------------------------------------------------
// Polygon metrics core - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_METRICS_CORE_DEFINES_SVH
`define POLYGON_METRICS_CORE_DEFINES_SVH

// Condition that must hold at every clock edge
`define PM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define PM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pm_pkg.sv
// ----------------------------------------------------------------------------
// Polygon metrics package
// Field widths, item types and shared constants of the polygon metrics core.
// ----------------------------------------------------------------------------
package pm_pkg;

  localparam int unsigned COORD_W          = 16;          // Q8.8 coordinate
  localparam int unsigned EXT_W            = COORD_W + 1; // sums and differences
  localparam int unsigned PROD_W           = 2 * EXT_W;   // one product
  localparam int unsigned AREA_W           = 41;
  localparam int unsigned PERIM_W          = 25;
  localparam int unsigned TOTAL_W          = 9;
  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pm_vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last;
  } pm_in_t;

  typedef struct packed {
    logic [AREA_W-1:0]         area;
    logic                      area_valid;
    logic                      convex;
    logic [PERIM_W-1:0]        perimeter;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic [TOTAL_W-1:0]        vertex_total;
    logic                      overflow;
  } pm_out_t;

  // Classification made by the front end
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_NEXT,
    KIND_DROP
  } pm_kind_e;

  typedef struct packed {
    pm_in_t   vtx;
    pm_kind_e kind;
  } pm_qitem_t;

endpackage

>>> hw/rtl/pm_queue.sv
// ----------------------------------------------------------------------------
// Polygon metrics item queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module pm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage, payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/pm_isqrt.sv
// ----------------------------------------------------------------------------
// Polygon metrics square root
// Truncated integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pm_isqrt #(
  parameter int unsigned RAD_W = 34
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);

  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned SC_W  = $clog2(RT_W + 1);

  logic              busy_q, done_q;
  logic [SC_W-1:0]   step_q;
  logic [RAD_W-1:0]  rad_q;
  logic [RT_W+1:0]   rem_q;
  logic [RT_W-1:0]   root_q;
  logic [RT_W+3:0]   rem_n, trial;
  logic              ge;

  // one digit step
  always_comb begin
    rem_n = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = (RT_W + 4)'({root_q, 2'b01});
    ge    = (rem_n >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SC_W'(RT_W);
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rem_q  <= ge ? (RT_W + 2)'(rem_n - trial) : (RT_W + 2)'(rem_n);
        root_q <= {root_q[RT_W-2:0], ge};
        step_q <= step_q - 1'b1;
        if (step_q == SC_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/pm_div.sv
// ----------------------------------------------------------------------------
// Polygon metrics divider
// Signed by unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pm_div #(
  parameter int unsigned DVD_W = 25,
  parameter int unsigned DVS_W = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W:0]   quotient_o
);

  localparam int unsigned SC_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [SC_W-1:0]  step_q;
  logic [DVD_W-1:0] dvd_q, quo_q, mag;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]   rem_n;
  logic             ge;

  always_comb begin
    mag   = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    rem_n = {rem_q, dvd_q[DVD_W-1]};
    ge    = (rem_n >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SC_W'(DVD_W);
        neg_q  <= dividend_i[DVD_W-1];
        dvd_q  <= mag;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
        rem_q  <= ge ? DVS_W'(rem_n - {1'b0, dvs_q}) : DVS_W'(rem_n);
        quo_q  <= {quo_q[DVD_W-2:0], ge};
        step_q <= step_q - 1'b1;
        if (step_q == SC_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // sign restored: truncation toward zero
  assign quotient_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign done_o     = done_q;

endmodule

>>> hw/rtl/pm_engine.sv
// ----------------------------------------------------------------------------
// Polygon metrics back end
// Sequencer over one shared multiplier, square root and dividers; result reg.
// ----------------------------------------------------------------------------
`include "polygon_metrics_core_defines.svh"

module pm_engine import pm_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  pm_qitem_t q_item_i,
  output logic      q_pop_o,
  output logic      res_valid_o,
  output pm_out_t   res_o,
  input  logic      res_pop_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SUM_W  = COORD_W + CNT_W;
  localparam int unsigned SHOE_W = PROD_W + CNT_W;
  localparam int unsigned MAG_W  = (SHOE_W > AREA_W) ? SHOE_W : AREA_W + 1;
  localparam int unsigned PS_W   = ((EXT_W > PERIM_W) ? EXT_W : PERIM_W) + 1;
  localparam int unsigned TOT_EW = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE_XX, ST_EDGE_YY, ST_EDGE_AREA, ST_EDGE_ROOT, ST_ROOT_WAIT,
    ST_CROSS_A, ST_CROSS_B, ST_CROSS_CHK, ST_UPDATE, ST_CLOSE, ST_DIV,
    ST_DIV_WAIT, ST_OUT
  } state_e;

  state_e                   state_q;
  pm_vtx_t                  first_q, second_q, prev_q, bprev_q, cur_q;
  pm_vtx_t                  ep_q, ec_q, ca_q, cb_q, cc_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SHOE_W-1:0] shoe_q;
  logic [PERIM_W-1:0]       perim_q;
  logic signed [SUM_W-1:0]  sumx_q, sumy_q;
  logic                     ref_q, convex_q, ovf_q, closing_q, last_q, corner2_q;
  logic signed [PROD_W-1:0] mul_q, crs_q;
  logic [PROD_W-1:0]        sq_q, rad_q;
  logic                     res_valid_q;
  pm_out_t                  res_q;

  logic signed [EXT_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   cross_diff;
  logic                     cross_neg;
  logic                     root_start, root_done, div_start, divx_done, divy_done;
  logic [EXT_W-1:0]         root;
  logic [PS_W-1:0]          perim_sum;
  logic signed [SUM_W:0]    quo_x, quo_y;
  logic [SHOE_W-1:0]        mag;
  logic [MAG_W-1:0]         mag_ext;
  logic [TOT_EW-1:0]        tot_ext;
  logic                     convex_eff, area_ok;
  pm_vtx_t                  vin;
  pm_out_t                  res_d;

  function automatic logic signed [EXT_W-1:0] ext(input logic signed [COORD_W-1:0] v);
    return EXT_W'(v);
  endfunction

  assign vin.x = q_item_i.vtx.vertex_x;
  assign vin.y = q_item_i.vtx.vertex_y;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_EDGE_XX: begin
        mul_a = ext(ep_q.x) - ext(ec_q.x);
        mul_b = mul_a;
      end
      ST_EDGE_YY: begin
        mul_a = ext(ep_q.y) - ext(ec_q.y);
        mul_b = mul_a;
      end
      ST_EDGE_AREA: begin
        mul_a = ext(ep_q.x) + ext(ec_q.x);
        mul_b = ext(ep_q.y) - ext(ec_q.y);
      end
      ST_CROSS_A: begin
        mul_a = ext(cb_q.x) - ext(ca_q.x);
        mul_b = ext(cc_q.y) - ext(cb_q.y);
      end
      ST_CROSS_B: begin
        mul_a = ext(cb_q.y) - ext(ca_q.y);
        mul_b = ext(cc_q.x) - ext(cb_q.x);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod       = mul_a * mul_b;
    cross_diff = (PROD_W + 1)'(crs_q) - (PROD_W + 1)'(mul_q);
    cross_neg  = cross_diff[PROD_W];
  end

  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign root_start = (state_q == ST_EDGE_ROOT);
  assign div_start  = (state_q == ST_DIV);
  assign perim_sum  = PS_W'(perim_q) + PS_W'(root);

  pm_isqrt #(.RAD_W(PROD_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (rad_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  pm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sumx_q),
    .divisor_i  (cnt_q),
    .done_o     (divx_done),
    .quotient_o (quo_x)
  );

  pm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sumy_q),
    .divisor_i  (cnt_q),
    .done_o     (divy_done),
    .quotient_o (quo_y)
  );

  // result assembly
  always_comb begin
    mag        = shoe_q[SHOE_W-1] ? SHOE_W'(-shoe_q) : SHOE_W'(shoe_q);
    mag_ext    = MAG_W'(mag);
    tot_ext    = TOT_EW'(cnt_q);
    convex_eff = convex_q && (cnt_q >= CNT_W'(3));
    area_ok    = convex_eff && (mag != '0);
    res_d.area         = !area_ok ? '0 :
                         (mag_ext > MAG_W'(AREA_MAX)) ? AREA_MAX : mag_ext[AREA_W-1:0];
    res_d.area_valid   = area_ok;
    res_d.convex       = convex_eff;
    res_d.perimeter    = perim_q;
    res_d.centroid_x   = (cnt_q == '0) ? '0 : quo_x[COORD_W-1:0];
    res_d.centroid_y   = (cnt_q == '0) ? '0 : quo_y[COORD_W-1:0];
    res_d.vertex_total = tot_ext[TOTAL_W-1:0];
    res_d.overflow     = ovf_q;
  end

  // sequencer, polygon state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= '0;
      second_q    <= '0;
      prev_q      <= '0;
      bprev_q     <= '0;
      cur_q       <= '0;
      ep_q        <= '0;
      ec_q        <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      cc_q        <= '0;
      cnt_q       <= '0;
      shoe_q      <= '0;
      perim_q     <= '0;
      sumx_q      <= '0;
      sumy_q      <= '0;
      ref_q       <= 1'b0;
      convex_q    <= 1'b1;
      ovf_q       <= 1'b0;
      closing_q   <= 1'b0;
      last_q      <= 1'b0;
      corner2_q   <= 1'b0;
      mul_q       <= '0;
      crs_q       <= '0;
      sq_q        <= '0;
      rad_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      // drain the result register; ST_OUT handles its own refill
      if (res_pop_i && res_valid_q && (state_q != ST_OUT)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            case (q_item_i.kind)
              KIND_DROP: begin
                ovf_q <= 1'b1;
                if (q_item_i.vtx.last) state_q <= ST_CLOSE;
              end
              KIND_FIRST: begin
                first_q <= vin;
                bprev_q <= prev_q;
                prev_q  <= vin;
                sumx_q  <= sumx_q + SUM_W'(vin.x);
                sumy_q  <= sumy_q + SUM_W'(vin.y);
                cnt_q   <= cnt_q + 1'b1;
                if (q_item_i.vtx.last) state_q <= ST_CLOSE;
              end
              default: begin
                cur_q     <= vin;
                ep_q      <= prev_q;
                ec_q      <= vin;
                last_q    <= q_item_i.vtx.last;
                closing_q <= 1'b0;
                state_q   <= ST_EDGE_XX;
              end
            endcase
          end
        end
        ST_EDGE_XX: begin
          mul_q   <= prod;
          state_q <= ST_EDGE_YY;
        end
        ST_EDGE_YY: begin
          sq_q    <= unsigned'(mul_q);
          mul_q   <= prod;
          state_q <= ST_EDGE_AREA;
        end
        ST_EDGE_AREA: begin
          rad_q   <= sq_q + unsigned'(mul_q);
          mul_q   <= prod;
          state_q <= ST_EDGE_ROOT;
        end
        ST_EDGE_ROOT: begin
          shoe_q  <= shoe_q + SHOE_W'(mul_q);
          state_q <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          if (root_done) begin
            perim_q <= (perim_sum > PS_W'(PERIM_MAX)) ? PERIM_MAX : perim_sum[PERIM_W-1:0];
            if (closing_q) begin
              if (cnt_q >= CNT_W'(3)) begin
                ca_q      <= bprev_q;
                cb_q      <= prev_q;
                cc_q      <= first_q;
                corner2_q <= 1'b1;
                state_q   <= ST_CROSS_A;
              end else begin
                state_q <= ST_DIV;
              end
            end else if (cnt_q >= CNT_W'(2)) begin
              ca_q    <= bprev_q;
              cb_q    <= prev_q;
              cc_q    <= cur_q;
              state_q <= ST_CROSS_A;
            end else begin
              state_q <= ST_UPDATE;
            end
          end
        end
        ST_CROSS_A: begin
          mul_q   <= prod;
          state_q <= ST_CROSS_B;
        end
        ST_CROSS_B: begin
          crs_q   <= mul_q;
          mul_q   <= prod;
          state_q <= ST_CROSS_CHK;
        end
        ST_CROSS_CHK: begin
          // first corner sets the reference sign, the rest must match it
          if (!closing_q && (cnt_q == CNT_W'(2))) begin
            ref_q <= cross_neg;
          end else if (cross_neg != ref_q) begin
            convex_q <= 1'b0;
          end
          if (!closing_q) begin
            state_q <= ST_UPDATE;
          end else if (corner2_q) begin
            ca_q      <= prev_q;
            cb_q      <= first_q;
            cc_q      <= second_q;
            corner2_q <= 1'b0;
            state_q   <= ST_CROSS_A;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_UPDATE: begin
          if (cnt_q == CNT_W'(1)) second_q <= cur_q;
          sumx_q  <= sumx_q + SUM_W'(cur_q.x);
          sumy_q  <= sumy_q + SUM_W'(cur_q.y);
          bprev_q <= prev_q;
          prev_q  <= cur_q;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= last_q ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          // wraparound edge from the last vertex back to the first
          closing_q <= 1'b1;
          if (cnt_q != '0) begin
            ep_q    <= prev_q;
            ec_q    <= first_q;
            state_q <= ST_EDGE_XX;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (divx_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid_q || res_pop_i) begin
            res_q       <= res_d;
            res_valid_q <= 1'b1;
            first_q     <= '0;
            second_q    <= '0;
            prev_q      <= '0;
            bprev_q     <= '0;
            cnt_q       <= '0;
            shoe_q      <= '0;
            perim_q     <= '0;
            sumx_q      <= '0;
            sumy_q      <= '0;
            ref_q       <= 1'b0;
            convex_q    <= 1'b1;
            ovf_q       <= 1'b0;
            closing_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `PM_ASSERT_IMPL(a_pop_has_item, q_pop_o, q_valid_i, "queue popped while empty")
  `PM_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(MAX_VERTICES), "vertex count past capacity")
  `PM_ASSERT_IMPL(a_root_expected, root_done, state_q == ST_ROOT_WAIT, "stray root result")
  `PM_ASSERT_IMPL(a_div_paired, divx_done, divy_done && state_q == ST_DIV_WAIT,
                  "divider results out of step")

endmodule

>>> hw/rtl/polygon_metrics_core.sv
// ----------------------------------------------------------------------------
// Polygon metrics core - top level
// Streams polygon vertices in and returns area, convexity, perimeter, centroid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one vertex per item on in_item_i, taken when push is high
//   and full is low. The item with last set closes the polygon.
//   Result channel: one result per polygon on out_item_o while empty is low,
//   taken when pop is high. A result waits in its own register, so the next
//   polygon's vertices keep flowing into the queue while the receiver stalls,
//   until the queue fills.
//   Per vertex, the back end forms up to five products on the shared
//   multiplier and runs the edge length through the 17-step square-root
//   unit, and it takes the next vertex only once it is through with the
//   last. The last vertex adds the closing edge, two corner checks and the
//   centroid division before the result appears.
//   The front end classifies each vertex (first, following, or dropped past
//   capacity) and queues it, so push sees a short queue, not the back end.
//   Reset clears the queue, all running sums and any pending result; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_metrics_core import pm_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  pm_in_t  in_item_i,
  output logic    empty,
  input  logic    pop,
  output pm_out_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] fcnt_q;
  logic             accept, q_empty, q_pop, res_valid;
  pm_qitem_t        f_item, q_item;
  logic [$bits(pm_qitem_t)-1:0] q_rdata;

  assign accept = push && !full;

  // front end: classify each vertex against the per-polygon count
  always_comb begin
    f_item.vtx = in_item_i;
    if (fcnt_q >= CNT_W'(MAX_VERTICES)) begin
      f_item.kind = KIND_DROP;
    end else if (fcnt_q == '0) begin
      f_item.kind = KIND_FIRST;
    end else begin
      f_item.kind = KIND_NEXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else if (accept) begin
      if (in_item_i.last) begin
        fcnt_q <= '0;
      end else if (f_item.kind != KIND_DROP) begin
        fcnt_q <= fcnt_q + 1'b1;
      end
    end
  end

  pm_queue #(.WIDTH($bits(pm_qitem_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign q_item = pm_qitem_t'(q_rdata);

  pm_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_o       (out_item_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Polygon metrics core - testbench
// Streams polygons of random and chosen shapes through the core, predicts the
// area, convexity, perimeter and centroid of each, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Running prediction of polygon metrics and the queue of expected results
class pm_metrics_board;
  pm_pkg::pm_out_t expected_q[$];
  int unsigned     n_errors;

  longint first_x, first_y, second_x, second_y;
  longint prev_x, prev_y, bprev_x, bprev_y;
  int unsigned count;
  longint shoelace, perim, sum_x, sum_y;
  bit     ref_neg, still_convex, ovf;

  function new();
    n_errors = 0;
    clear();
  endfunction

  function void clear();
    first_x = 0; first_y = 0; second_x = 0; second_y = 0;
    prev_x = 0; prev_y = 0; bprev_x = 0; bprev_y = 0;
    count = 0; shoelace = 0; perim = 0; sum_x = 0; sum_y = 0;
    ref_neg = 0; still_convex = 1; ovf = 0;
  endfunction

  function bit turns_negative(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
    return ((bx - ax) * (cy - by) - (by - ay) * (cx - bx)) < 0;
  endfunction

  function longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function void add_edge(longint px, longint py, longint cx, longint cy);
    shoelace += (px + cx) * (py - cy);
    perim += int_sqrt((px - cx) * (px - cx) + (py - cy) * (py - cy));
    if (perim > 33554431) perim = 33554431;
  endfunction

  // Note one accepted vertex item
  function void note_vertex(pm_pkg::pm_in_t it, int unsigned max_v);
    longint x, y, mag;
    bit neg, cvx;
    pm_pkg::pm_out_t r;
    x = longint'(it.vertex_x);
    y = longint'(it.vertex_y);
    if (count >= max_v) begin
      ovf = 1;
    end else begin
      if (count == 0) begin
        first_x = x; first_y = y;
      end else begin
        add_edge(prev_x, prev_y, x, y);
        if (count == 1) begin
          second_x = x; second_y = y;
        end else begin
          neg = turns_negative(bprev_x, bprev_y, prev_x, prev_y, x, y);
          if (count == 2) ref_neg = neg;
          else if (neg != ref_neg) still_convex = 0;
        end
      end
      sum_x += x; sum_y += y;
      bprev_x = prev_x; bprev_y = prev_y;
      prev_x = x; prev_y = y;
      count++;
    end
    if (!it.last) return;
    if (count >= 1) add_edge(prev_x, prev_y, first_x, first_y);
    cvx = 0;
    if (count >= 3) begin
      if (turns_negative(bprev_x, bprev_y, prev_x, prev_y, first_x, first_y) != ref_neg)
        still_convex = 0;
      if (turns_negative(prev_x, prev_y, first_x, first_y, second_x, second_y) != ref_neg)
        still_convex = 0;
      cvx = still_convex;
    end
    mag = (shoelace < 0) ? -shoelace : shoelace;
    if (mag > 64'h1FF_FFFF_FFFF) mag = 64'h1FF_FFFF_FFFF;
    r.area         = (cvx && mag != 0) ? mag[40:0] : '0;
    r.area_valid   = cvx && mag != 0;
    r.convex       = cvx;
    r.perimeter    = perim[24:0];
    r.centroid_x   = (count != 0) ? 16'(sum_x / longint'(count)) : '0;
    r.centroid_y   = (count != 0) ? 16'(sum_y / longint'(count)) : '0;
    r.vertex_total = count[8:0];
    r.overflow     = ovf;
    expected_q.push_back(r);
    clear();
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(pm_pkg::pm_out_t got);
    pm_pkg::pm_out_t e;
    if (expected_q.size() == 0) begin
      $error("result with no polygon outstanding: %p", got);
      n_errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.area !== e.area) begin
      $error("area exp %0d got %0d", e.area, got.area); n_errors++;
    end
    if (got.area_valid !== e.area_valid) begin
      $error("area_valid exp %0d got %0d", e.area_valid, got.area_valid); n_errors++;
    end
    if (got.convex !== e.convex) begin
      $error("convex exp %0d got %0d", e.convex, got.convex); n_errors++;
    end
    if (got.perimeter !== e.perimeter) begin
      $error("perimeter exp %0d got %0d", e.perimeter, got.perimeter); n_errors++;
    end
    if (got.centroid_x !== e.centroid_x) begin
      $error("centroid_x exp %0d got %0d", e.centroid_x, got.centroid_x); n_errors++;
    end
    if (got.centroid_y !== e.centroid_y) begin
      $error("centroid_y exp %0d got %0d", e.centroid_y, got.centroid_y); n_errors++;
    end
    if (got.vertex_total !== e.vertex_total) begin
      $error("vertex_total exp %0d got %0d", e.vertex_total, got.vertex_total);
      n_errors++;
    end
    if (got.overflow !== e.overflow) begin
      $error("overflow exp %0d got %0d", e.overflow, got.overflow); n_errors++;
    end
  endfunction
endclass

module tb;
  import pm_pkg::*;

  localparam int unsigned MAX_V = MAX_VERTICES_DEF;

  logic    clk_i, rst_ni, push, full, empty, pop;
  pm_in_t  in_item;
  pm_out_t out_item;

  pm_metrics_board board;
  bit      quiet;         // no idling in the closing stretch
  bit      drive_done;
  int      items_sent;

  polygon_metrics_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one vertex; push stays high across back-to-back items
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit lst);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{vertex_x: x, vertex_y: y, last: lst};
    do @(posedge clk_i); while (full);
    board.note_vertex(in_item, MAX_V);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  // Regular convex polygon approximation around a random centre
  task automatic send_convex(int n, int radius);
    real ang;
    int cx, cy, px, py;
    cx = $urandom_range(0, 20000) - 10000;
    cy = $urandom_range(0, 20000) - 10000;
    for (int i = 0; i < n; i++) begin
      ang = 6.283185307 * i / n;
      px = cx + $rtoi(radius * $cos(ang));
      py = cy + $rtoi(radius * $sin(ang));
      send_vertex(16'(px), 16'(py), i == n - 1);
    end
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_vertex(16'($urandom), 16'($urandom), i == n - 1);
  endtask

  // Receiver with random stall bursts
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && pop && !empty) board.check_result(out_item);

  initial begin
    int n;
    board = new();
    push = 1'b0;
    in_item = '0;
    quiet = 0;
    drive_done = 0;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single vertex, two vertices, extremes, a square, a concave shape
    send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
    send_vertex(16'sh8000, 16'sh7FFF, 1'b0);
    send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_vertex(16'sh8000, 16'sh7FFF, 1'b1);
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd100, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd0, 16'sd100, 1'b1);
    // Collinear: zero area, still convex
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b1);
    // Clockwise triangle
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd256, 1'b0);
    send_vertex(16'sd256, 16'sd0, 1'b1);
    send_vertex(-16'sd1, -16'sd1, 1'b1);

    // Sender holds off until every result is back
    idle_input();
    while (board.expected_q.size() != 0) @(negedge clk_i);

    // Overflow: more vertices than capacity, the vertices past capacity dropped
    for (int i = 0; i < MAX_V + 3; i++)
      send_vertex(16'($urandom), 16'($urandom), i == MAX_V + 2);

    // Random polygons, mostly convex
    while (items_sent < 650) begin
      if (items_sent > 550) quiet = 1;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) send_convex($urandom_range(3, 9), $urandom_range(1, 20000));
      else send_random(n);
    end
    idle_input();
    drive_done = 1;
  end

  initial begin
    wait (drive_done);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.n_errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
